[hw/rtl/channel_switch_announce_fsm_macros.svh]
// Assertion macros used by the block's top-level RTL file.
`ifndef CHANNEL_SWITCH_ANNOUNCE_FSM_MACROS_SVH
`define CHANNEL_SWITCH_ANNOUNCE_FSM_MACROS_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define CSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/csa_pkg.sv]
package csa_pkg;

  localparam int AllowSlots      = 8;
  localparam int MaxChannel      = 200;
  localparam int DriftLimitMs    = 20;
  localparam int DefaultRevertMs = 3000;

  localparam int NowW    = 48;
  localparam int TimeW   = 50;
  localparam int InDataW = 160;
  localparam int OutDataW = 72;

  localparam logic [2:0] RegCooldown  = 3'd0;
  localparam logic [2:0] RegNoRevert  = 3'd1;
  localparam logic [2:0] RegChanCount = 3'd2;
  localparam logic [2:0] RegChanList  = 3'd3;
  localparam logic [2:0] RegBwMask    = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_ARMED  = 3'b010,
    MODE_VERIFY = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    CMD_COMMIT = 2'd0,
    CMD_ALIVE  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_MALFORMED = 4'd1,
    EV_RANGE     = 4'd2,
    EV_CHAN      = 4'd3,
    EV_BW        = 4'd4,
    EV_COOLDOWN  = 4'd5,
    EV_ARMED     = 4'd6,
    EV_REFRESH   = 4'd7,
    EV_DRIFT     = 4'd8,
    EV_COMMITTED = 4'd9,
    EV_SWITCHED  = 4'd10,
    EV_REVERTED  = 4'd11,
    EV_VERIFY    = 4'd12
  } event_e;

  localparam logic [1:0] StateIdle   = 2'd0;
  localparam logic [1:0] StateArmed  = 2'd1;
  localparam logic [1:0] StateVerify = 2'd2;

  typedef struct packed {
    logic [19:0] hold_off_ms;
    logic        direct_commit;
    logic [3:0]  allow_chan_count;
    logic [63:0] allow_chan_list;
    logic [7:0]  allow_bw_mask;
  } cfg_t;

  typedef struct packed {
    logic range_ok;
    logic chan_ok;
    logic bw_ok;
  } check_t;

  function automatic logic [1:0] state_code(mode_e mode);
    logic [1:0] code;
    case (mode)
      MODE_ARMED:  code = StateArmed;
      MODE_VERIFY: code = StateVerify;
      default:     code = StateIdle;
    endcase
    return code;
  endfunction

endpackage

[hw/rtl/csa_check.sv]
module csa_check (
  input  csa_pkg::cfg_t   cfg_i,
  input  logic [7:0]      chan_i,
  input  logic [2:0]      bw_i,
  output csa_pkg::check_t check_o
);

  logic [3:0] slots;
  logic [csa_pkg::AllowSlots-1:0] hit;

  always_comb begin
    if (cfg_i.allow_chan_count > 4'(csa_pkg::AllowSlots)) begin
      slots = 4'(csa_pkg::AllowSlots);
    end else begin
      slots = cfg_i.allow_chan_count;
    end
    for (int i = 0; i < csa_pkg::AllowSlots; i++) begin
      hit[i] = (4'(i) < slots) && (cfg_i.allow_chan_list[8*i +: 8] == chan_i);
    end
  end

  assign check_o.range_ok = (chan_i != 8'd0) && (chan_i <= 8'(csa_pkg::MaxChannel));
  assign check_o.chan_ok  = (cfg_i.allow_chan_count == 4'd0) || (|hit);
  assign check_o.bw_ok    = (cfg_i.allow_bw_mask == 8'd0) || cfg_i.allow_bw_mask[bw_i];

endmodule

[hw/rtl/channel_switch_announce_fsm.sv]
// An accepted input waits in the input register; its result enters the output
// register once that is empty or being read. Throughput: one item per cycle
// unless the output stalls; input and output registers each stage one item,
// and all checks and state updates are done in a single pass between them.
// Reset (rst_ni low, asynchronous) clears the mode, the hop history, all state
// and the configuration registers, and empties both stages.
`include "channel_switch_announce_fsm_macros.svh"

module channel_switch_announce_fsm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // now_ms, frame_ok, session, delay_ms, has_revert, revert_ms, target_channel,
  // target_bw, prev_channel, prev_bw, zero padding
  input  logic [csa_pkg::InDataW-1:0] s_tdata_i,
  // cmd
  input  logic [1:0]  s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // do_set, out_channel, out_bw, event_code, next_deadline_ms, state_now,
  // zero padding
  output logic [csa_pkg::OutDataW-1:0] m_tdata_o
);

  csa_pkg::cfg_t cfg_q;

  logic                        in_valid_q;
  logic [csa_pkg::InDataW-1:0] in_data_q;
  logic [1:0]                  in_user_q;
  logic                        out_valid_q;
  logic [67:0]                 out_data_q, out_data_d;
  logic                        adv;

  csa_pkg::mode_e           mode_q, mode_d;
  logic [31:0]              cur_session_q, cur_session_d;
  logic signed [49:0]       switch_at_q, switch_at_d;
  logic signed [49:0]       revert_time_q, revert_time_d;
  logic [7:0]               tgt_chan_q, tgt_chan_d;
  logic [2:0]               tgt_bw_q, tgt_bw_d;
  logic [7:0]               prv_chan_q, prv_chan_d;
  logic [2:0]               prv_bw_q, prv_bw_d;
  logic [csa_pkg::NowW-1:0] last_hop_q, last_hop_d;
  logic                     last_hop_valid_q, last_hop_valid_d;

  logic [csa_pkg::NowW-1:0] now;
  logic                     frame_ok;
  logic [31:0]              session;
  logic [31:0]              delay;
  logic                     has_revert;
  logic [19:0]              revert_ms;
  logic [7:0]               target_channel;
  logic [2:0]               target_bw;
  logic [7:0]               prev_channel;
  logic [2:0]               prev_bw;
  csa_pkg::cmd_e            cmd;

  csa_pkg::check_t    chk;
  logic signed [49:0] now_s;
  logic signed [49:0] instant;
  logic signed [50:0] delta;
  logic signed [48:0] since;
  logic               cooldown_hold;
  logic               drift_ok;

  logic               set;
  logic [7:0]         och;
  logic [2:0]         obw;
  csa_pkg::event_e    ev;
  logic signed [49:0] deadline;

  logic [3:0]         res_ev;
  logic               res_hop;
  logic               res_armed;
  logic               res_in_armed;

  localparam logic signed [50:0] DriftLim = 51'(csa_pkg::DriftLimitMs);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        csa_pkg::RegCooldown:  cfg_q.hold_off_ms      <= cfg_data_i[19:0];
        csa_pkg::RegNoRevert:  cfg_q.direct_commit    <= cfg_data_i[0];
        csa_pkg::RegChanCount: cfg_q.allow_chan_count <= cfg_data_i[3:0];
        csa_pkg::RegChanList:  cfg_q.allow_chan_list  <= cfg_data_i;
        csa_pkg::RegBwMask:    cfg_q.allow_bw_mask    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign adv        = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tready_o) begin
        in_valid_q <= s_tvalid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_data_q <= s_tdata_i;
      in_user_q <= s_tuser_i;
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign now            = in_data_q[47:0];
  assign frame_ok       = in_data_q[48];
  assign session        = in_data_q[80:49];
  assign delay          = in_data_q[112:81];
  assign has_revert     = in_data_q[113];
  assign revert_ms      = in_data_q[133:114];
  assign target_channel = in_data_q[141:134];
  assign target_bw      = in_data_q[144:142];
  assign prev_channel   = in_data_q[152:145];
  assign prev_bw        = in_data_q[155:153];
  assign cmd            = csa_pkg::cmd_e'(in_user_q);

  csa_check u_check (
    .cfg_i  (cfg_q),
    .chan_i (target_channel),
    .bw_i   (target_bw),
    .check_o(chk)
  );

  assign now_s   = $signed({2'b00, now});
  assign instant = now_s + $signed({{18{delay[31]}}, delay});
  assign delta   = $signed({instant[49], instant}) - $signed({switch_at_q[49], switch_at_q});
  assign drift_ok = (delta <= DriftLim) && (delta >= -DriftLim);
  assign since   = $signed({1'b0, now}) - $signed({1'b0, last_hop_q});
  assign cooldown_hold = (cfg_q.hold_off_ms != 20'd0) && last_hop_valid_q &&
                         (since < $signed({29'd0, cfg_q.hold_off_ms}));

  always_comb begin
    mode_d           = mode_q;
    cur_session_d    = cur_session_q;
    switch_at_d      = switch_at_q;
    revert_time_d    = revert_time_q;
    tgt_chan_d       = tgt_chan_q;
    tgt_bw_d         = tgt_bw_q;
    prv_chan_d       = prv_chan_q;
    prv_bw_d         = prv_bw_q;
    last_hop_d       = last_hop_q;
    last_hop_valid_d = last_hop_valid_q;
    set      = 1'b0;
    och      = 8'd0;
    obw      = 3'd0;
    ev       = csa_pkg::EV_NONE;
    deadline = '0;
    case (cmd)
      csa_pkg::CMD_COMMIT: begin
        if (!frame_ok) begin
          ev = csa_pkg::EV_MALFORMED;
        end else if (!chk.range_ok) begin
          ev = csa_pkg::EV_RANGE;
        end else if (!chk.chan_ok) begin
          ev = csa_pkg::EV_CHAN;
        end else if (!chk.bw_ok) begin
          ev = csa_pkg::EV_BW;
        end else if (mode_q == csa_pkg::MODE_VERIFY && session == cur_session_q) begin
          mode_d = csa_pkg::MODE_IDLE;
          ev     = csa_pkg::EV_COMMITTED;
        end else if (mode_q == csa_pkg::MODE_IDLE || session > cur_session_q) begin
          if (cooldown_hold) begin
            ev = csa_pkg::EV_COOLDOWN;
          end else begin
            mode_d        = csa_pkg::MODE_ARMED;
            cur_session_d = session;
            switch_at_d   = instant;
            revert_time_d = has_revert ? $signed({30'd0, revert_ms})
                                       : $signed(50'(csa_pkg::DefaultRevertMs));
            tgt_chan_d    = target_channel;
            tgt_bw_d      = target_bw;
            prv_chan_d    = prev_channel;
            prv_bw_d      = prev_bw;
            ev            = csa_pkg::EV_ARMED;
          end
        end else if (mode_q == csa_pkg::MODE_ARMED && session == cur_session_q) begin
          ev = drift_ok ? csa_pkg::EV_REFRESH : csa_pkg::EV_DRIFT;
        end
      end
      csa_pkg::CMD_ALIVE: begin
        if (mode_q == csa_pkg::MODE_VERIFY) begin
          mode_d = csa_pkg::MODE_IDLE;
          ev     = csa_pkg::EV_COMMITTED;
        end
      end
      csa_pkg::CMD_TICK: begin
        if (mode_q == csa_pkg::MODE_ARMED) begin
          if (now_s >= switch_at_q) begin
            set              = 1'b1;
            och              = tgt_chan_q;
            obw              = tgt_bw_q;
            last_hop_d       = now;
            last_hop_valid_d = 1'b1;
            if (cfg_q.direct_commit) begin
              mode_d = csa_pkg::MODE_IDLE;
              ev     = csa_pkg::EV_SWITCHED;
            end else begin
              mode_d        = csa_pkg::MODE_VERIFY;
              revert_time_d = now_s + revert_time_q;
              ev            = csa_pkg::EV_VERIFY;
              deadline      = now_s + revert_time_q;
            end
          end else begin
            deadline = switch_at_q;
          end
        end else if (mode_q == csa_pkg::MODE_VERIFY) begin
          if (now_s >= revert_time_q) begin
            set              = 1'b1;
            och              = prv_chan_q;
            obw              = prv_bw_q;
            last_hop_d       = now;
            last_hop_valid_d = 1'b1;
            mode_d           = csa_pkg::MODE_IDLE;
            ev               = csa_pkg::EV_REVERTED;
          end else begin
            deadline = revert_time_q;
          end
        end
      end
      default: begin
      end
    endcase
    out_data_d = {csa_pkg::state_code(mode_d), deadline, ev, obw, och, set};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= csa_pkg::MODE_IDLE;
      cur_session_q    <= '0;
      switch_at_q      <= '0;
      revert_time_q    <= '0;
      tgt_chan_q       <= '0;
      tgt_bw_q         <= '0;
      prv_chan_q       <= '0;
      prv_bw_q         <= '0;
      last_hop_q       <= '0;
      last_hop_valid_q <= 1'b0;
    end else if (adv) begin
      mode_q           <= mode_d;
      cur_session_q    <= cur_session_d;
      switch_at_q      <= switch_at_d;
      revert_time_q    <= revert_time_d;
      tgt_chan_q       <= tgt_chan_d;
      tgt_bw_q         <= tgt_bw_d;
      prv_chan_q       <= prv_chan_d;
      prv_bw_q         <= prv_bw_d;
      last_hop_q       <= last_hop_d;
      last_hop_valid_q <= last_hop_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'd0, out_data_q};

  assign res_ev       = m_tdata_o[15:12];
  assign res_hop      = (res_ev == csa_pkg::EV_SWITCHED) || (res_ev == csa_pkg::EV_VERIFY) ||
                        (res_ev == csa_pkg::EV_REVERTED);
  assign res_armed    = (res_ev == csa_pkg::EV_ARMED);
  assign res_in_armed = (m_tdata_o[67:66] == csa_pkg::StateArmed);

  `CSA_ASSERT_IMPL(a_hop_sets, m_tvalid_o && res_hop, m_tdata_o[0], "Hop without tuning.")
  `CSA_ASSERT_IMPL(a_armed_state, m_tvalid_o && res_armed, res_in_armed, "Armed state missing.")
  `CSA_ASSERT_NEXT(a_hop_sticky, last_hop_valid_q, last_hop_valid_q, "Hop history was lost.")

endmodule

[sim/tb_channel_switch_announce_fsm.sv]
module tb_channel_switch_announce_fsm;
  import csa_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 150;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  pad;
    logic [2:0]  prev_bw;
    logic [7:0]  prev_channel;
    logic [2:0]  target_bw;
    logic [7:0]  target_channel;
    logic [19:0] revert_ms;
    logic        has_revert;
    logic [31:0] delay_ms;
    logic [31:0] session;
    logic        frame_ok;
    logic [47:0] now_ms;
  } csa_item_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [1:0]  state_now;
    logic [49:0] next_deadline_ms;
    logic [3:0]  event_code;
    logic [2:0]  out_bw;
    logic [7:0]  out_channel;
    logic        do_set;
  } csa_action_t;

  class csa_scoreboard;
    logic [19:0] hold_off_ms;
    logic        direct_commit;
    logic [3:0]  chan_count;
    logic [63:0] chan_list;
    logic [7:0]  bw_mask;

    logic [1:0]  fsm_state;
    logic [31:0] cur_session;
    longint      switch_at;
    longint      revert_time;
    logic [7:0]  tgt_chan;
    logic [2:0]  tgt_bw;
    logic [7:0]  prv_chan;
    logic [2:0]  prv_bw;
    logic [47:0] last_hop_ms;
    logic        hop_seen;

    csa_action_t action_q[$];
    int          errors;

    function new();
      hold_off_ms   = '0;
      direct_commit = 1'b0;
      chan_count    = '0;
      chan_list     = '0;
      bw_mask       = '0;
      fsm_state     = StateIdle;
      cur_session   = '0;
      switch_at     = 0;
      revert_time   = 0;
      tgt_chan      = '0;
      tgt_bw        = '0;
      prv_chan      = '0;
      prv_bw        = '0;
      last_hop_ms   = '0;
      hop_seen      = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        RegCooldown:  hold_off_ms   = value[19:0];
        RegNoRevert:  direct_commit = value[0];
        RegChanCount: chan_count    = value[3:0];
        RegChanList:  chan_list     = value;
        RegBwMask:    bw_mask       = value[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return action_q.size();
    endfunction

    function bit chan_allowed(logic [7:0] ch);
      int n;
      n = chan_count;
      if (n == 0) return 1'b1;
      if (n > AllowSlots) n = AllowSlots;
      for (int i = 0; i < n; i++) begin
        if (chan_list[8*i +: 8] == ch) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [3:0] commit_event(csa_item_t it, longint now_l);
      longint instant;
      longint delta;
      if (!it.frame_ok) return EV_MALFORMED;
      if (it.target_channel < 1 || it.target_channel > MaxChannel) return EV_RANGE;
      if (!chan_allowed(it.target_channel)) return EV_CHAN;
      if (bw_mask != '0 && !bw_mask[it.target_bw]) return EV_BW;
      instant = now_l + longint'($signed(it.delay_ms));
      if (fsm_state == StateVerify && it.session == cur_session) begin
        fsm_state = StateIdle;
        return EV_COMMITTED;
      end
      if (fsm_state == StateIdle || it.session > cur_session) begin
        if (hold_off_ms != '0 && hop_seen &&
            (now_l - longint'({16'd0, last_hop_ms})) < longint'({44'd0, hold_off_ms}))
          return EV_COOLDOWN;
        fsm_state   = StateArmed;
        cur_session = it.session;
        switch_at   = instant;
        revert_time = it.has_revert ? longint'({44'd0, it.revert_ms}) : DefaultRevertMs;
        tgt_chan    = it.target_channel;
        tgt_bw      = it.target_bw;
        prv_chan    = it.prev_channel;
        prv_bw      = it.prev_bw;
        return EV_ARMED;
      end
      if (fsm_state == StateArmed && it.session == cur_session) begin
        delta = instant - switch_at;
        if (delta < 0) delta = -delta;
        return (delta <= DriftLimitMs) ? EV_REFRESH : EV_DRIFT;
      end
      return EV_NONE;
    endfunction

    function void predict_action(csa_item_t it);
      csa_action_t act;
      longint      now_l;
      longint      deadline;
      act      = '0;
      deadline = 0;
      now_l    = longint'({16'd0, it.now_ms});
      case (it.cmd)
        CMD_COMMIT: begin
          act.event_code = commit_event(it, now_l);
        end
        CMD_ALIVE: begin
          if (fsm_state == StateVerify) begin
            fsm_state      = StateIdle;
            act.event_code = EV_COMMITTED;
          end
        end
        CMD_TICK: begin
          if (fsm_state == StateArmed) begin
            if (now_l >= switch_at) begin
              act.do_set      = 1'b1;
              act.out_channel = tgt_chan;
              act.out_bw      = tgt_bw;
              last_hop_ms     = it.now_ms;
              hop_seen        = 1'b1;
              if (direct_commit) begin
                fsm_state      = StateIdle;
                act.event_code = EV_SWITCHED;
              end else begin
                fsm_state      = StateVerify;
                revert_time    = now_l + revert_time;
                act.event_code = EV_VERIFY;
                deadline       = revert_time;
              end
            end else begin
              deadline = switch_at;
            end
          end else if (fsm_state == StateVerify) begin
            if (now_l >= revert_time) begin
              act.do_set      = 1'b1;
              act.out_channel = prv_chan;
              act.out_bw      = prv_bw;
              last_hop_ms     = it.now_ms;
              hop_seen        = 1'b1;
              fsm_state       = StateIdle;
              act.event_code  = EV_REVERTED;
            end else begin
              deadline = revert_time;
            end
          end
        end
        default: ;
      endcase
      act.next_deadline_ms = deadline[49:0];
      act.state_now        = fsm_state;
      action_q.push_back(act);
    endfunction

    function void field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_action(logic [OutDataW-1:0] data);
      csa_action_t exp_a;
      csa_action_t got;
      got = data;
      if (action_q.size() == 0) begin
        $error("result transaction with no expected action, data %0h", data);
        errors++;
        return;
      end
      exp_a = action_q.pop_front();
      field_check("do_set", exp_a.do_set, got.do_set);
      field_check("out_channel", exp_a.out_channel, got.out_channel);
      field_check("out_bw", exp_a.out_bw, got.out_bw);
      field_check("event_code", exp_a.event_code, got.event_code);
      field_check("next_deadline_ms", exp_a.next_deadline_ms, got.next_deadline_ms);
      field_check("state_now", exp_a.state_now, got.state_now);
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [2:0]          cfg_addr_i  = '0;
  logic [63:0]         cfg_data_i  = '0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i   = '0;
  logic [1:0]          s_tuser_i   = '0;
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;

  csa_scoreboard sb;
  bit            idle_on = 1'b1;
  logic [47:0]   clock_ms = 48'd0;
  int            quiet_cycles = 0;

  channel_switch_announce_fsm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      sb.check_action(m_tdata_o);
    end
  end

  task automatic send(csa_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= it[InDataW-1:0];
    s_tuser_i  <= it.cmd;
    do @(posedge clk_i); while (!s_tready_o);
    sb.predict_action(it);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [19:0] cooldown, logic no_rev, logic [3:0] count,
                            logic [63:0] list, logic [7:0] mask);
    logic [2:0]  regs [5];
    logic [63:0] vals [5];
    regs = '{RegCooldown, RegNoRevert, RegChanCount, RegChanList, RegBwMask};
    vals = '{{44'd0, cooldown}, {63'd0, no_rev}, {60'd0, count}, list, {56'd0, mask}};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic csa_item_t mk(logic [1:0] cmd, logic [47:0] now, logic [31:0] sess,
                                   int delay, logic [7:0] tch);
    csa_item_t it;
    it                = '0;
    it.cmd            = cmd;
    it.now_ms         = now;
    it.frame_ok       = 1'b1;
    it.session        = sess;
    it.delay_ms       = delay;
    it.target_channel = tch;
    it.prev_channel   = 8'd36;
    it.prev_bw        = 3'd1;
    return it;
  endfunction

  function automatic logic [63:0] random_list();
    logic [63:0] list;
    for (int i = 0; i < 8; i++)
      list[8*i +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(1, MaxChannel));
    return list;
  endfunction

  function automatic logic [7:0] pick_channel();
    int n;
    n = (sb.chan_count > AllowSlots) ? AllowSlots : sb.chan_count;
    if (n == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(1, MaxChannel));
    return sb.chan_list[8*$urandom_range(0, n-1) +: 8];
  endfunction

  function automatic logic [2:0] pick_bw();
    logic [2:0] bw;
    bw = 3'($urandom);
    if (sb.bw_mask == '0 || $urandom_range(0, 9) == 0) return bw;
    while (!sb.bw_mask[bw]) bw = 3'($urandom);
    return bw;
  endfunction

  function automatic csa_item_t random_item();
    csa_item_t it;
    int        r;
    int        pick;
    longint    want;
    r = $urandom_range(0, 99);
    if (r < 3) clock_ms = {16'($urandom), 32'($urandom)};
    else if (r < 6) clock_ms = clock_ms + $urandom_range(0, 5000);
    else clock_ms = clock_ms + $urandom_range(0, 30);
    it                = '0;
    it.now_ms         = clock_ms;
    it.frame_ok       = 1'b1;
    it.session        = $urandom;
    it.delay_ms       = $urandom;
    it.has_revert     = $urandom_range(0, 1);
    it.revert_ms      = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 400));
    it.target_channel = 8'($urandom);
    it.target_bw      = 3'($urandom);
    it.prev_channel   = 8'($urandom);
    it.prev_bw        = 3'($urandom);
    it.pad            = '0;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it.cmd = CMD_COMMIT;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        it.frame_ok = 1'b0;
      end else if (pick >= 12) begin
        it.target_channel = pick_channel();
        it.target_bw      = pick_bw();
        if ($urandom_range(0, 9) != 0) it.delay_ms = $urandom_range(0, 260) - 10;
        pick = $urandom_range(0, 9);
        if (sb.fsm_state == StateIdle) begin
          if (pick >= 2) it.session = sb.cur_session + $urandom_range(0, 3);
        end else if (pick < 5) begin
          it.session = sb.cur_session;
          if (sb.fsm_state == StateArmed) begin
            want = sb.switch_at - longint'({16'd0, clock_ms}) + $urandom_range(0, 50) - 25;
            it.delay_ms = want[31:0];
          end
        end else if (pick < 8) begin
          it.session = sb.cur_session + $urandom_range(1, 4);
        end else begin
          it.session = sb.cur_session - $urandom_range(1, 4);
        end
      end
    end else if (r < 52) begin
      it.cmd = CMD_ALIVE;
    end else if (r < 55) begin
      it.cmd = CMD_UNUSED;
    end else begin
      it.cmd = CMD_TICK;
      if ($urandom_range(0, 4) == 0) begin
        if (sb.fsm_state == StateArmed && sb.switch_at >= 0 && sb.switch_at < (64'd1 << 48))
          clock_ms = sb.switch_at[47:0];
        else if (sb.fsm_state == StateVerify && sb.revert_time < (64'd1 << 48))
          clock_ms = sb.revert_time[47:0];
        it.now_ms = clock_ms;
      end
    end
    return it;
  endfunction

  initial begin
    csa_item_t it;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_config(20'd0, 1'b0, 4'd0, 64'd0, 8'd0);

    send(mk(CMD_TICK, 48'hFFFF_FFFF_FFFF, 0, 0, 1));
    send(mk(CMD_COMMIT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 1));
    send(mk(CMD_TICK, 48'hFFFF_FFFF_FFFF, 0, 0, 1));
    send(mk(CMD_ALIVE, 48'hFFFF_FFFF_FFFF, 0, 0, 1));
    it = mk(CMD_COMMIT, 1000, 5, 100, 36);
    it.frame_ok = 1'b0;
    send(it);
    send(mk(CMD_COMMIT, 1000, 5, 100, 0));
    send(mk(CMD_COMMIT, 1000, 5, 100, 255));
    send(mk(CMD_UNUSED, 1000, 5, 100, 36));
    send(mk(CMD_ALIVE, 1000, 0, 0, 36));
    it = mk(CMD_COMMIT, 1000, 5, 100, 200);
    it.target_bw    = 3'd7;
    it.prev_channel = 8'd255;
    it.prev_bw      = 3'd7;
    send(it);
    send(mk(CMD_COMMIT, 1010, 5, 110, 200));
    send(mk(CMD_COMMIT, 1010, 5, 111, 200));
    send(mk(CMD_COMMIT, 1020, 4, 0, 200));
    send(mk(CMD_TICK, 1099, 0, 0, 1));
    send(mk(CMD_TICK, 1100, 0, 0, 1));
    send(mk(CMD_TICK, 4099, 0, 0, 1));
    send(mk(CMD_COMMIT, 4099, 5, 0, 1));
    it = mk(CMD_COMMIT, 5000, 6, -5, 1);
    it.has_revert = 1'b1;
    send(it);
    send(mk(CMD_TICK, 5000, 0, 0, 1));
    send(mk(CMD_TICK, 5000, 0, 0, 1));
    it = mk(CMD_COMMIT, 6000, 7, 0, 100);
    it.has_revert = 1'b1;
    it.revert_ms  = 20'hFFFFF;
    send(it);
    send(mk(CMD_TICK, 6000, 0, 0, 1));
    send(mk(CMD_COMMIT, 6001, 9, 0, 50));
    send(mk(CMD_TICK, 6001, 0, 0, 1));
    send(mk(CMD_ALIVE, 6002, 0, 0, 1));
    drain();

    set_config(20'd100, 1'b1, 4'd2, 64'h0000_0000_0000_2824, 8'h05);
    send(mk(CMD_COMMIT, 6050, 20, 0, 37));
    it = mk(CMD_COMMIT, 6050, 20, 0, 36);
    it.target_bw = 3'd1;
    send(it);
    it.target_bw = 3'd2;
    send(it);
    send(mk(CMD_COMMIT, 6101, 20, 0, 40));
    send(mk(CMD_TICK, 6101, 0, 0, 1));
    clock_ms = 48'd7000;

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: set_config(20'd0, 1'b0, 4'd0, 64'd0, 8'd0);
        1: set_config(20'd150, 1'b0, 4'd3, random_list(), 8'h0F);
        2: set_config(20'd0, 1'b1, 4'd8, random_list(), 8'hFF);
        3: set_config(20'hFFFFF, 1'b0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80);
        default: set_config(20'($urandom_range(0, 300)), 1'($urandom), 4'($urandom),
                            random_list(),
                            ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send(random_item());
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/csa_pkg.sv
hw/rtl/csa_check.sv
hw/rtl/channel_switch_announce_fsm.sv
sim/tb_channel_switch_announce_fsm.sv
